// ===== design/sp3q_pkg.sv =====
// Package for the three-class strict-priority tag queue.
// Holds sizes, codes, the controller state type and pointer helpers.
// No dependencies.
package sp3q_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 32;
  localparam int NUM_CLASSES = 3;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [1:0]           cls_t;

  localparam cls_t CLS_HIGH = 2'd0;
  localparam cls_t CLS_MED  = 2'd1;
  localparam cls_t CLS_LOW  = 2'd2;

  localparam cnt_t CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam ptr_t PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOAD = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } sp3q_cmd_t;

  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
    return r;
  endfunction

  function automatic addr_t slot_addr(input cls_t c, input ptr_t p);
    addr_t r;
    r = ADDR_W'(c * QUEUE_DEPTH) + ADDR_W'(p);
    return r;
  endfunction

endpackage

// ===== design/sp3q_req_if.sv =====
// Request channel of the priority tag queue: valid, ready and payload.
// Depends on nothing.
interface sp3q_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  item_class;
  logic [31:0] item_tag;

  modport source (output valid, operation, item_class, item_tag, input ready);
  modport sink   (input valid, operation, item_class, item_tag, output ready);
endinterface

// ===== design/sp3q_rsp_if.sv =====
// Response channel of the priority tag queue: valid, ready and payload.
// Depends on nothing.
interface sp3q_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] served_tag;
  logic [1:0]  served_class;
  logic [2:0]  nonempty_mask;

  modport source (output valid, status, served_tag, served_class, nonempty_mask,
                  input ready);
  modport sink   (input valid, status, served_tag, served_class, nonempty_mask,
                  output ready);
endinterface

// ===== design/sp3q_ctrl.sv =====
// Controller of the priority tag queue: request acceptance, result load
// and the output valid flag. Depends on sp3q_pkg.
module sp3q_ctrl
  import sp3q_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sp3q_cmd_t cmd
);

  state_t state, state_next;
  logic   vld;
  logic   vld_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld   <= 1'b0;
    end else begin
      state <= state_next;
      vld   <= vld_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    vld_next     = vld && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready   = !vld || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        vld_next     = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid = vld;

endmodule

// ===== design/sp3q_datapath.sv =====
// Datapath of the priority tag queue: tag memory, per-class pointers and
// counts, result and output registers. Depends on sp3q_pkg.
module sp3q_datapath
  import sp3q_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sp3q_cmd_t   cmd,
  input  logic        operation,
  input  logic [1:0]  item_class,
  input  logic [31:0] item_tag,
  output logic [1:0]  status,
  output logic [31:0] served_tag,
  output logic [1:0]  served_class,
  output logic [2:0]  nonempty_mask
);

  tag_t mem [MEM_DEPTH];
  tag_t rdata;

  ptr_t head  [NUM_CLASSES];
  ptr_t tail  [NUM_CLASSES];
  cnt_t count [NUM_CLASSES];

  status_t res_status;
  cls_t    res_class;
  logic    res_served;

  cls_t    enq_cls;
  cls_t    deq_cls;
  logic    any_ne;
  logic    is_deq;
  logic    full;
  logic    wr_en;
  addr_t   wr_addr;
  addr_t   rd_addr;
  status_t st_next;
  logic    served_next;
  logic [NUM_CLASSES-1:0] ne;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      ne[c] = (count[c] != '0);
    end
  end

  always_comb begin
    is_deq  = (op_t'(operation) == OP_DEQ);
    enq_cls = (item_class > CLS_LOW) ? CLS_LOW : item_class;
    full    = (count[enq_cls] == CNT_FULL);
    any_ne  = |ne;
    if (ne[CLS_HIGH]) begin
      deq_cls = CLS_HIGH;
    end else if (ne[CLS_MED]) begin
      deq_cls = CLS_MED;
    end else begin
      deq_cls = CLS_LOW;
    end
    wr_en   = !is_deq && !full;
    wr_addr = slot_addr(enq_cls, tail[enq_cls]);
    rd_addr = slot_addr(deq_cls, head[deq_cls]);
    served_next = is_deq && any_ne;
    if (is_deq) begin
      st_next = any_ne ? ST_OK : ST_EMPTY;
    end else begin
      st_next = full ? ST_FULL : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
    end else if (cmd.accept) begin
      if (wr_en) begin
        tail[enq_cls]  <= ptr_adv(tail[enq_cls]);
        count[enq_cls] <= CNT_W'(count[enq_cls] + 1'b1);
      end
      if (served_next) begin
        head[deq_cls]  <= ptr_adv(head[deq_cls]);
        count[deq_cls] <= CNT_W'(count[deq_cls] - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= TAG_WIDTH'(item_tag);
    end
    if (cmd.accept) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= st_next;
      res_class  <= served_next ? deq_cls : CLS_HIGH;
      res_served <= served_next;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      served_tag    <= res_served ? 32'(rdata) : '0;
      served_class  <= res_class;
      nonempty_mask <= 3'(ne);
    end
  end

endmodule

// ===== design/strict_priority_three_class_queue.sv =====
// Strict-priority scheduler over three tag queues (high, medium, low).
// An accepted request moves the controller to S_LOAD, which fills the output
// registers and sets the valid flag. No request is taken in S_LOAD or while
// a response waits for ready. Synchronous reset empties all queues at once;
// the tag memory itself is not cleared and needs no clearing pass.
module strict_priority_three_class_queue
  import sp3q_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sp3q_req_if.sink    req,
  sp3q_rsp_if.source  rsp
);

  sp3q_cmd_t cmd;

  sp3q_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  sp3q_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (req.operation),
    .item_class    (req.item_class),
    .item_tag      (req.item_tag),
    .status        (rsp.status),
    .served_tag    (rsp.served_tag),
    .served_class  (rsp.served_class),
    .nonempty_mask (rsp.nonempty_mask)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !req.ready)
    else $error("request accepted while previous one in flight");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> ##2 rsp.valid)
    else $error("response not valid two cycles after request");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |->
      (rsp.nonempty_mask == 3'd0 && rsp.served_tag == 32'd0))
    else $error("empty response with entries or tag");

  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.nonempty_mask != 3'd0))
    else $error("full response with all queues empty");

endmodule
